### src/sgbi_pkg.sv
// Shared types and constants for the sparse grid bounding-box index.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sgbi_pkg;

   // List and table geometry
   localparam int MAX_TILES   = 256;
   localparam int TILE_AW     = $clog2(MAX_TILES);
   localparam int COUNT_W     = TILE_AW + 1;
   localparam int TABLE_DEPTH = 4096;
   localparam int CELL_AW     = $clog2(TABLE_DEPTH);
   localparam int CELL_W      = COUNT_W;
   localparam int COORD_W     = 16;
   localparam int SIZE_W      = COORD_W + 1;
   localparam int AREA_W      = 2 * SIZE_W;
   localparam int SIDE_W      = CELL_AW + 1;

   // Command codes of the request word
   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_REBUILD = 2'd2,
      CMD_LOOKUP  = 2'd3
   } cmd_type;

   // Status codes of the response word
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_AREA = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } tile_type;

   typedef struct packed {
      logic                 en;
      logic [TILE_AW-1:0]   addr;
      tile_type             data;
   } tile_wr_type;

   typedef struct packed {
      logic                 en;
      logic [CELL_AW-1:0]   addr;
      logic [CELL_W-1:0]    data;
   } cell_wr_type;

endpackage

`default_nettype wire

### src/sgbi_tile_list.sv
// Tile coordinate list: one write port, one registered read port.
// Depends on sgbi_pkg for the tile word and write port types.
`default_nettype none

module sgbi_tile_list (
   input  wire                             clock,
   input  wire sgbi_pkg::tile_wr_type      wr,
   input  wire [sgbi_pkg::TILE_AW-1:0]     rd_addr,
   output sgbi_pkg::tile_type              rd_data
);

   sgbi_pkg::tile_type tiles_mem [sgbi_pkg::MAX_TILES];
   sgbi_pkg::tile_type rd_data_ff;

   // Write on request, read every cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         tiles_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= tiles_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/sgbi_cell_table.sv
// Dense cell table holding tile index plus one, zero for an empty cell.
// Depends on sgbi_pkg for widths and the write port type.
`default_nettype none

module sgbi_cell_table (
   input  wire                             clock,
   input  wire sgbi_pkg::cell_wr_type      wr,
   input  wire [sgbi_pkg::CELL_AW-1:0]     rd_addr,
   output logic [sgbi_pkg::CELL_W-1:0]     rd_data
);

   logic [sgbi_pkg::CELL_W-1:0] cells_mem [sgbi_pkg::TABLE_DEPTH];
   logic [sgbi_pkg::CELL_W-1:0] rd_data_ff;

   // Write on request, read every cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         cells_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= cells_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/sparse_grid_bbox_index_core.sv
// Sparse grid bounding-box index: command sequencer around the tile list and cell table.
// Depends on sgbi_pkg, sgbi_tile_list and sgbi_cell_table.
//
// Usage:
//   A request word (req_cmd, req_coord_x, req_coord_y) is taken when req_valid and
//   req_ready are both high; exactly one response word follows on the rsp_ channel.
//   Commands: clear list, append tile, rebuild box and table, look up a coordinate.
//   Every response carries the box as it stands after the command.
//   Clear and append go from the idle step straight to the result step. A rebuild
//   scans the list, sizes the box, zeroes its area with one table write per cycle
//   and fills the table, with one list read per cycle in the scan and the fill.
//   Items are handled one at a time: the next request is taken only once the
//   previous result has been handed to the output register.
//   The response sits in an output register, so the next request is taken while
//   an earlier response waits; a stalled receiver holds the response and, once
//   the following command is finished, the sequencer waits for the register.
//   Reset empties the list, zeroes the box and marks the table empty. The table
//   memory itself needs no clearing: no cell outside a rebuilt box is ever used.
`default_nettype none

module sparse_grid_bbox_index_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [1:0]                           req_cmd,
   input  wire  signed [15:0]                   req_coord_x,
   input  wire  signed [15:0]                   req_coord_y,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_found,
   output logic [7:0]                           rsp_tile_number,
   output logic signed [15:0]                   rsp_box_left,
   output logic signed [15:0]                   rsp_box_top,
   output logic [16:0]                          rsp_box_width,
   output logic [16:0]                          rsp_box_height
);

   localparam int COUNT_W = sgbi_pkg::COUNT_W;
   localparam int TILE_AW = sgbi_pkg::TILE_AW;
   localparam int CELL_AW = sgbi_pkg::CELL_AW;
   localparam int CELL_W  = sgbi_pkg::CELL_W;
   localparam int COORD_W = sgbi_pkg::COORD_W;
   localparam int SIZE_W  = sgbi_pkg::SIZE_W;
   localparam int AREA_W  = sgbi_pkg::AREA_W;
   localparam int SIDE_W  = sgbi_pkg::SIDE_W;
   localparam int PROD_W  = CELL_AW + SIDE_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SIZE,
      ST_AREA,
      ST_CHECK,
      ST_ZERO,
      ST_FILL,
      ST_LK_BOUND,
      ST_LK_INDEX,
      ST_LK_READ,
      ST_LK_DATA,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   sgbi_pkg::cmd_type           cmd_code;
   logic signed [COORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic signed [COORD_W-1:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic [SIZE_W-1:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic                        table_ok_ff, table_ok_in;
   logic signed [COORD_W-1:0]   minx_ff, minx_in, maxx_ff, maxx_in;
   logic signed [COORD_W-1:0]   miny_ff, miny_in, maxy_ff, maxy_in;
   logic [COUNT_W-1:0]          issue_ff, issue_in;
   logic                        rvalid_ff, rvalid_in;
   logic [CELL_W-1:0]           rnum_ff, rnum_in;
   logic                        p2_valid_ff, p2_valid_in;
   logic [CELL_AW-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [CELL_W-1:0]           ent2_ff, ent2_in;
   logic                        p3_valid_ff, p3_valid_in;
   logic [CELL_AW-1:0]          idx_ff, idx_in;
   logic [CELL_W-1:0]           ent3_ff, ent3_in;
   logic [AREA_W-1:0]           area_ff, area_in;
   logic [CELL_AW-1:0]          zero_ff, zero_in;
   logic                        inbox_ff, inbox_in;
   logic [1:0]                  res_status_ff, res_status_in;
   logic                        res_found_ff, res_found_in;
   logic [7:0]                  res_number_ff, res_number_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [7:0]                  rsp_number_ff, rsp_number_in;
   logic signed [COORD_W-1:0]   rsp_left_ff, rsp_left_in, rsp_top_ff, rsp_top_in;
   logic [SIZE_W-1:0]           rsp_width_ff, rsp_width_in, rsp_height_ff, rsp_height_in;

   sgbi_pkg::tile_wr_type       tile_wr;
   sgbi_pkg::tile_type          tile_rd;
   sgbi_pkg::cell_wr_type       cell_wr;
   logic [CELL_W-1:0]           cell_rd;

   logic                        req_take;
   logic                        rsp_free;
   logic [SIZE_W-1:0]           span_x, span_y;
   logic [SIZE_W-1:0]           dxs, dys;
   logic [PROD_W-1:0]           prod;
   logic [CELL_AW-1:0]          cell_idx;
   logic [CELL_W-1:0]           cell_minus;

   // Memories
   sgbi_tile_list u_tile_list (
      .clock   (clock),
      .wr      (tile_wr),
      .rd_addr (issue_ff[TILE_AW-1:0]),
      .rd_data (tile_rd)
   );

   sgbi_cell_table u_cell_table (
      .clock   (clock),
      .wr      (cell_wr),
      .rd_addr (idx_ff),
      .rd_data (cell_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_code  = sgbi_pkg::cmd_type'(req_cmd);

   // Box side lengths, lookup offsets and cell index
   assign span_x     = {maxx_ff[COORD_W-1], maxx_ff} - {minx_ff[COORD_W-1], minx_ff};
   assign span_y     = {maxy_ff[COORD_W-1], maxy_ff} - {miny_ff[COORD_W-1], miny_ff};
   assign dxs        = {x_ff[COORD_W-1], x_ff} - {ox_ff[COORD_W-1], ox_ff};
   assign dys        = {y_ff[COORD_W-1], y_ff} - {oy_ff[COORD_W-1], oy_ff};
   assign prod       = {{SIDE_W{1'b0}}, dy_ff} * {{CELL_AW{1'b0}}, sx_ff[SIDE_W-1:0]};
   assign cell_idx   = prod[CELL_AW-1:0] + dx_ff;
   assign cell_minus = cell_rd - CELL_W'(1);

   // Next-state and datapath
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      count_in      = count_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      table_ok_in   = table_ok_ff;
      minx_in       = minx_ff;
      maxx_in       = maxx_ff;
      miny_in       = miny_ff;
      maxy_in       = maxy_ff;
      issue_in      = issue_ff;
      rvalid_in     = 1'b0;
      rnum_in       = rnum_ff;
      p2_valid_in   = 1'b0;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      ent2_in       = ent2_ff;
      p3_valid_in   = 1'b0;
      idx_in        = idx_ff;
      ent3_in       = ent3_ff;
      area_in       = area_ff;
      zero_in       = zero_ff;
      inbox_in      = inbox_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_number_in = res_number_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_number_in = rsp_number_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_height_in = rsp_height_ff;
      tile_wr.en    = 1'b0;
      tile_wr.addr  = count_ff[TILE_AW-1:0];
      tile_wr.data  = '{x: req_coord_x, y: req_coord_y};
      cell_wr.en    = 1'b0;
      cell_wr.addr  = zero_ff;
      cell_wr.data  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_in          = req_coord_x;
               y_in          = req_coord_y;
               res_status_in = sgbi_pkg::STATUS_OK;
               res_found_in  = 1'b0;
               res_number_in = '0;
               unique case (cmd_code)
                  sgbi_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  sgbi_pkg::CMD_APPEND: begin
                     if (count_ff >= COUNT_W'(sgbi_pkg::MAX_TILES)) begin
                        res_status_in = sgbi_pkg::STATUS_FULL;
                     end else begin
                        tile_wr.en = 1'b1;
                        count_in   = count_ff + COUNT_W'(1);
                     end
                     state_in = ST_DONE;
                  end
                  sgbi_pkg::CMD_REBUILD: begin
                     table_ok_in = 1'b0;
                     if (count_ff == '0) begin
                        ox_in    = '0;
                        oy_in    = '0;
                        sx_in    = '0;
                        sy_in    = '0;
                        state_in = ST_DONE;
                     end else begin
                        minx_in  = {1'b0, {(COORD_W-1){1'b1}}};
                        miny_in  = {1'b0, {(COORD_W-1){1'b1}}};
                        maxx_in  = {1'b1, {(COORD_W-1){1'b0}}};
                        maxy_in  = {1'b1, {(COORD_W-1){1'b0}}};
                        issue_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  sgbi_pkg::CMD_LOOKUP: begin
                     state_in = ST_LK_BOUND;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Walk the list and track the extremes
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               issue_in  = issue_ff + COUNT_W'(1);
               rvalid_in = 1'b1;
            end
            if (rvalid_ff) begin
               if (tile_rd.x < minx_ff) minx_in = tile_rd.x;
               if (tile_rd.x > maxx_ff) maxx_in = tile_rd.x;
               if (tile_rd.y < miny_ff) miny_in = tile_rd.y;
               if (tile_rd.y > maxy_ff) maxy_in = tile_rd.y;
            end
            if (issue_ff == count_ff && !rvalid_ff) begin
               state_in = ST_SIZE;
            end
         end

         ST_SIZE: begin
            ox_in    = minx_ff;
            oy_in    = miny_ff;
            sx_in    = span_x + SIZE_W'(1);
            sy_in    = span_y + SIZE_W'(1);
            state_in = ST_AREA;
         end

         ST_AREA: begin
            area_in  = {{SIZE_W{1'b0}}, sx_ff} * {{SIZE_W{1'b0}}, sy_ff};
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (area_ff > AREA_W'(sgbi_pkg::TABLE_DEPTH)) begin
               res_status_in = sgbi_pkg::STATUS_AREA;
               state_in      = ST_DONE;
            end else begin
               zero_in  = '0;
               state_in = ST_ZERO;
            end
         end

         // Clear the cells covered by the box, one per cycle
         ST_ZERO: begin
            cell_wr.en = 1'b1;
            zero_in    = zero_ff + CELL_AW'(1);
            if (zero_ff == CELL_AW'(area_ff - AREA_W'(1))) begin
               issue_in = '0;
               state_in = ST_FILL;
            end
         end

         // Read tiles, form the cell index, write index plus one in list order
         ST_FILL: begin
            if (issue_ff < count_ff) begin
               issue_in  = issue_ff + COUNT_W'(1);
               rnum_in   = issue_ff + COUNT_W'(1);
               rvalid_in = 1'b1;
            end
            p2_valid_in = rvalid_ff;
            dx_in       = CELL_AW'(tile_rd.x - ox_ff);
            dy_in       = CELL_AW'(tile_rd.y - oy_ff);
            ent2_in     = rnum_ff;
            p3_valid_in = p2_valid_ff;
            idx_in      = cell_idx;
            ent3_in     = ent2_ff;
            cell_wr.en   = p3_valid_ff;
            cell_wr.addr = idx_ff;
            cell_wr.data = ent3_ff;
            if (issue_ff == count_ff && !rvalid_ff && !p2_valid_ff && !p3_valid_ff) begin
               table_ok_in = 1'b1;
               state_in    = ST_DONE;
            end
         end

         // Bounds check against the box
         ST_LK_BOUND: begin
            inbox_in = table_ok_ff && !dxs[SIZE_W-1] && !dys[SIZE_W-1]
                       && (dxs < sx_ff) && (dys < sy_ff);
            dx_in    = dxs[CELL_AW-1:0];
            dy_in    = dys[CELL_AW-1:0];
            state_in = ST_LK_INDEX;
         end

         ST_LK_INDEX: begin
            idx_in   = cell_idx;
            state_in = ST_LK_READ;
         end

         ST_LK_READ: begin
            state_in = ST_LK_DATA;
         end

         ST_LK_DATA: begin
            if (inbox_ff && cell_rd != '0) begin
               res_status_in = sgbi_pkg::STATUS_OK;
               res_found_in  = 1'b1;
               res_number_in = cell_minus[7:0];
            end else begin
               res_status_in = sgbi_pkg::STATUS_MISS;
            end
            state_in = ST_DONE;
         end

         // Hand the word to the output register once it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_number_in = res_number_ff;
               rsp_left_in   = ox_ff;
               rsp_top_in    = oy_ff;
               rsp_width_in  = sx_ff;
               rsp_height_in = sy_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         table_ok_ff  <= 1'b0;
         rvalid_ff    <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         table_ok_ff  <= table_ok_in;
         rvalid_ff    <= rvalid_in;
         p2_valid_ff  <= p2_valid_in;
         p3_valid_ff  <= p3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      minx_ff       <= minx_in;
      maxx_ff       <= maxx_in;
      miny_ff       <= miny_in;
      maxy_ff       <= maxy_in;
      issue_ff      <= issue_in;
      rnum_ff       <= rnum_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      ent2_ff       <= ent2_in;
      idx_ff        <= idx_in;
      ent3_ff       <= ent3_in;
      area_ff       <= area_in;
      zero_ff       <= zero_in;
      inbox_ff      <= inbox_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_number_ff <= res_number_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_number_ff <= rsp_number_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_height_ff <= rsp_height_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_tile_number = rsp_number_ff;
   assign rsp_box_left    = rsp_left_ff;
   assign rsp_box_top     = rsp_top_ff;
   assign rsp_box_width   = rsp_width_ff;
   assign rsp_box_height  = rsp_height_ff;

endmodule

`default_nettype wire
